// ----- hw/rtl/sobel_abs_gradient_stream_core_macros.svh -----
// assertion macros shared by the sobel gradient checker
`ifndef SOBEL_ABS_GRADIENT_STREAM_CORE_MACROS_SVH
`define SOBEL_ABS_GRADIENT_STREAM_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SAG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sag assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sag assertion failed");

// next-cycle implication that is also checked during reset
`define SAG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sag assertion failed");

`endif

// ----- hw/rtl/sag_pkg.sv -----
// types, constants and helper functions of the sobel gradient stream core
`default_nettype none

package sag_pkg;

    // widths fixed by the stream fields
    localparam int PIX_W        = 8;
    localparam int FW_W         = 11;
    localparam int FH_W         = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int SUM_W        = 10;
    localparam int DIFF_W       = 11;

    // defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
    localparam int OUT_FIFO_DEPTH = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = 1'b1;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } sag_col_t;

    // per-word control carried along the pipeline
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } sag_ctl_t;

    // result word as it is queued for the output
    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] gy;
        logic [PIX_W-1:0] gx;
    } sag_out_word_t;

    // weighted 1-2-1 sum of three pixels
    function automatic logic [SUM_W-1:0] sum121(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
        sum121 = SUM_W'(a) + {1'b0, b, 1'b0} + SUM_W'(c);
    endfunction

    // absolute value of a signed difference, saturated to a byte
    function automatic logic [PIX_W-1:0] abs_sat(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] mag;
        mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        abs_sat = (mag > DIFF_W'(255)) ? 8'hFF : mag[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sag_line_store.sv -----
// two line memories with registered read and read-modify-write update
`default_nettype none

module sag_line_store #(
    parameter int MAX_WIDTH = sag_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
    input  wire logic [sag_pkg::PIX_W-1:0]        wr_px,
    output logic      [sag_pkg::PIX_W-1:0]        rd_top,
    output logic      [sag_pkg::PIX_W-1:0]        rd_mid
);
    import sag_pkg::*;

    // previous row and the row before it
    logic [PIX_W-1:0] store_a [MAX_WIDTH];
    logic [PIX_W-1:0] store_b [MAX_WIDTH];

    // synchronous read, registered on rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_mid <= store_a[rd_addr];
            rd_top <= store_b[rd_addr];
        end
    end

    // write back: previous row moves down, new pixel enters the mid store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_a[wr_addr] <= wr_px;
            store_b[wr_addr] <= rd_mid;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sag_window.sv -----
// 3x3 window shift register and sobel gradient stage
`default_nettype none

module sag_window (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire sag_pkg::sag_ctl_t         ctl_in,
    input  wire logic [sag_pkg::PIX_W-1:0] top,
    input  wire logic [sag_pkg::PIX_W-1:0] mid,
    input  wire logic [sag_pkg::PIX_W-1:0] px,
    output logic                           res_valid,
    output sag_pkg::sag_out_word_t         res_word
);
    import sag_pkg::*;

    sag_col_t win_reg [3];
    sag_ctl_t ctl_reg;

    logic [SUM_W-1:0] right_sum, left_sum, bot_sum, top_sum;
    logic signed [DIFF_W-1:0] gx_diff, gy_diff;

    // window shifts left by one column per word
    always_ff @(posedge aclk) begin
        if (ctl_in.valid) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= '{top: top, mid: mid, bot: px};
        end
    end

    // control of the word now held in the window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    // kernel sums
    always_comb begin
        right_sum = sum121(win_reg[2].top, win_reg[2].mid, win_reg[2].bot);
        left_sum  = sum121(win_reg[0].top, win_reg[0].mid, win_reg[0].bot);
        bot_sum   = sum121(win_reg[0].bot, win_reg[1].bot, win_reg[2].bot);
        top_sum   = sum121(win_reg[0].top, win_reg[1].top, win_reg[2].top);
        gx_diff   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        gy_diff   = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    end

    assign res_valid     = ctl_reg.valid && ctl_reg.emit;
    assign res_word.gx   = abs_sat(gx_diff);
    assign res_word.gy   = abs_sat(gy_diff);
    assign res_word.last = ctl_reg.last;

endmodule

`default_nettype wire

// ----- hw/rtl/sag_out_fifo.sv -----
// small output queue that decouples the pipeline from the receiver
`default_nettype none

module sag_out_fifo (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     push,
    input  wire sag_pkg::sag_out_word_t                   push_word,
    input  wire logic                                     pop,
    output logic                                          not_empty,
    output sag_pkg::sag_out_word_t                        head_word,
    output logic [$clog2(sag_pkg::OUT_FIFO_DEPTH):0]      count
);
    import sag_pkg::*;

    localparam int PW = $clog2(OUT_FIFO_DEPTH);

    sag_out_word_t   mem_reg [OUT_FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + (PW+1)'(1);
                2'b01:   count_reg <= count_reg - (PW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sobel_abs_gradient_stream_core.sv -----
// top level of the 3x3 sobel absolute gradient stream core
// Usage:
//   s_ channel: one 8-bit grayscale pixel per word, raster order.
//   m_ channel: one word per interior centre pixel, |gx| in tdata[7:0],
//   |gy| in tdata[15:8], both saturated at 255; tlast marks the final
//   interior result of a frame. Border pixels give no word.
//   cfg channel: index 0 writes frame_width, index 1 frame_height; write
//   only while the core is idle. cfg_ready is always high.
// Pipeline: an accepted pixel passes the line-memory read, the window update
//   and the output queue write, in that order, before its result shows on
//   m_tvalid and can be taken.
// Throughput: one pixel per cycle while s_tready is high; each pixel is one
//   read and one write of the two line memories, which never see two pixels
//   in flight at the same column, because a row has at least three columns.
// Reset: aresetn clears counters, pipeline and queue; registers return to
//   640 x 480. Line memories are not cleared; the first two rows fill them.
// Stall: the four-entry output queue holds results; s_tready drops once
//   queued plus in-flight words would exceed it, so nothing is lost.
`default_nettype none

module sobel_abs_gradient_stream_core #(
    parameter int MAX_WIDTH = sag_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // pixel in: tdata[7:0] pixel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,
    // result out: tdata[7:0] grad_x_abs, tdata[15:8] grad_y_abs
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata,
    output logic                                    m_tlast,
    // register writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sag_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sag_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = ((WW > FW_W) ? WW : FW_W) + 1;
    localparam int QCW   = $clog2(OUT_FIFO_DEPTH) + 1;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [AW-1:0]    col_reg;
    logic [FH_W-1:0]  row_reg;
    logic             run_reg;

    logic [AW-1:0]    p1_col_reg;
    logic [PIX_W-1:0] p1_px_reg;
    sag_ctl_t         p1_ctl_reg;

    logic [CMPW-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic             row_end, frame_end, emit, accept;
    logic [AW-1:0]    col_next;
    logic [FH_W-1:0]  row_next;

    logic [PIX_W-1:0] rd_top, rd_mid;
    logic             res_valid;
    sag_out_word_t    res_word, head_word;
    logic [QCW-1:0]   q_count;
    logic [QCW:0]     q_load;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                CFG_IDX_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
            endcase
        end
    end

    // sizes in use and position bookkeeping
    always_comb begin
        if (frame_width_reg < FW_W'(3)) begin
            w_eff = CMPW'(3);
        end else if (CMPW'(frame_width_reg) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(frame_width_reg);
        end
        h_eff     = (frame_height_reg < FH_W'(3)) ? FH_W'(3) : frame_height_reg;
        row_end   = (CMPW'(col_reg) + CMPW'(1)) >= w_eff;
        frame_end = row_end && (({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff});
        emit      = (row_reg >= FH_W'(2)) && (col_reg >= AW'(2));
        col_next  = row_end ? '0 : AW'(CMPW'(col_reg) + CMPW'(1));
        row_next  = row_end ? (frame_end ? '0 : row_reg + FH_W'(1)) : row_reg;
    end

    // position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage one: word waits for the line memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_ctl_reg <= '0;
        end else begin
            p1_ctl_reg <= '{valid: accept, emit: emit, last: frame_end};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_col_reg <= col_reg;
            p1_px_reg  <= s_tdata;
        end
    end

    // input flow control: queue entries plus words still in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
        end
    end

    assign q_load   = (QCW+1)'(q_count) + (QCW+1)'(p1_ctl_reg.valid)
                    + (QCW+1)'(res_valid);
    assign s_tready = run_reg && (q_load < (QCW+1)'(OUT_FIFO_DEPTH));

    sag_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (p1_ctl_reg.valid),
        .wr_addr (p1_col_reg),
        .wr_px   (p1_px_reg),
        .rd_top  (rd_top),
        .rd_mid  (rd_mid)
    );

    sag_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (p1_ctl_reg),
        .top       (rd_top),
        .mid       (rd_mid),
        .px        (p1_px_reg),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    sag_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_word (res_word),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head_word (head_word),
        .count     (q_count)
    );

    // output word
    assign m_tdata = {head_word.gy, head_word.gx};
    assign m_tlast = head_word.last;

endmodule

`default_nettype wire

// ----- hw/rtl/sobel_abs_gradient_stream_core_checker.sv -----
// port-level checker for the sobel gradient stream core, bound to the top level
`default_nettype none

`include "sobel_abs_gradient_stream_core_macros.svh"

module sobel_abs_gradient_stream_core_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    logic s_acc;
    logic acc_d1_reg, acc_d2_reg, rst_d1_reg;
    logic quiet_in;

    // input handshake and its recent history
    assign s_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        acc_d1_reg <= s_acc;
        acc_d2_reg <= acc_d1_reg;
        rst_d1_reg <= aresetn;
    end

    // out of reset per rst_d1_reg, no word taken per acc_d1_reg or acc_d2_reg
    assign quiet_in = rst_d1_reg && !acc_d1_reg && !acc_d2_reg;

    // reset leaves no result pending
    `SAG_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid)

    // a held result stays offered
    `SAG_ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // a result appearing on an empty output comes from an accepted input word
    `SAG_ASSERT_IMPL(a_result_has_source, aclk, aresetn, $rose(m_tvalid), $past(s_acc, 3))

    // an empty core with nothing in flight takes input
    `SAG_ASSERT_IMPL(a_idle_ready, aclk, aresetn, !m_tvalid && quiet_in, s_tready)

endmodule

bind sobel_abs_gradient_stream_core sobel_abs_gradient_stream_core_checker u_checker (.*);

`default_nettype wire

// ----- verif/sobel_abs_gradient_stream_core_tb.sv -----
// self-checking testbench of the sobel absolute gradient stream core
`timescale 1ns / 1ps

module sobel_abs_gradient_stream_core_tb;
    import sag_pkg::*;

    localparam int MAX_W          = MAX_WIDTH_DEF;
    localparam int WIDTH_AT_RESET = 640;
    localparam int HEIGHT_AT_RST  = 480;
    localparam int SMALL_ITEMS    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    // one result word, field by field
    typedef struct packed {
        logic [7:0] gx_abs;
        logic [7:0] gy_abs;
        logic       frame_end;
    } grad_word_t;

    // one pixel of the directed part, with an optional hand-written result
    typedef struct packed {
        logic [7:0] pix;
        logic       typed;
        logic       has_word;
        grad_word_t want;
    } dir_row_t;

    localparam grad_word_t NO_WORD = '{8'd0, 8'd0, 1'b0};
    localparam grad_word_t GX_SAT  = '{8'd255, 8'd0, 1'b1};
    localparam grad_word_t GY_SAT  = '{8'd0, 8'd255, 1'b1};

    // three 3x3 frames: only the centre pixel of each gives a word
    dir_row_t dir_rows [27] = '{
        // dark left column, bright right column: |gx| saturates
        '{8'd0,   1'b1, 1'b0, NO_WORD}, '{8'd0,   1'b1, 1'b0, NO_WORD},
        '{8'd255, 1'b1, 1'b0, NO_WORD}, '{8'd0,   1'b1, 1'b0, NO_WORD},
        '{8'd0,   1'b1, 1'b0, NO_WORD}, '{8'd255, 1'b1, 1'b0, NO_WORD},
        '{8'd0,   1'b1, 1'b0, NO_WORD}, '{8'd0,   1'b1, 1'b0, NO_WORD},
        '{8'd255, 1'b1, 1'b1, GX_SAT},
        // bright top row, dark below: |gy| saturates from a negative sum
        '{8'd255, 1'b1, 1'b0, NO_WORD}, '{8'd255, 1'b1, 1'b0, NO_WORD},
        '{8'd255, 1'b1, 1'b0, NO_WORD}, '{8'd0,   1'b1, 1'b0, NO_WORD},
        '{8'd0,   1'b1, 1'b0, NO_WORD}, '{8'd0,   1'b1, 1'b0, NO_WORD},
        '{8'd0,   1'b1, 1'b0, NO_WORD}, '{8'd0,   1'b1, 1'b0, NO_WORD},
        '{8'd0,   1'b1, 1'b1, GY_SAT},
        // sums of exactly +255 and -255, just short of the clip
        '{8'd0,   1'b0, 1'b0, NO_WORD}, '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd255, 1'b0, 1'b0, NO_WORD}, '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd1,   1'b0, 1'b0, NO_WORD}, '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD}, '{8'd0,   1'b0, 1'b0, NO_WORD},
        '{8'd0,   1'b0, 1'b0, NO_WORD}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirror of the block: registers, line stores, window and position
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    int              line_one_up [MAX_W];
    int              line_two_up [MAX_W];
    int              win [3][3];
    int              col_pos;
    int              row_pos;

    grad_word_t grads_due [$];
    int         mismatch_count = 0;
    int         sent_count     = 0;
    int         taken_count    = 0;
    int         small_items    = 0;

    sobel_abs_gradient_stream_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always #5 aclk = ~aclk;

    // magnitude of a sobel sum, clipped to a byte
    function automatic logic [7:0] clip_mag(input int v);
        int m;
        m = (v < 0) ? -v : v;
        return (m > 255) ? 8'hFF : 8'(m);
    endfunction

    // advance the mirror by one pixel and work out the word it causes
    function automatic void predict_gradient(input logic [7:0] pix, output bit has_word,
                                             output grad_word_t word);
        int w;
        int h;
        int above;
        int above2;
        int gx;
        int gy;
        w = (width_reg < 3) ? 3 : int'(width_reg);
        if (w > MAX_W)
            w = MAX_W;
        h = (height_reg < 3) ? 3 : int'(height_reg);

        // column of the line stores moves up by one row
        above2 = line_two_up[col_pos];
        above  = line_one_up[col_pos];
        line_two_up[col_pos] = above;
        line_one_up[col_pos] = int'(pix);

        // window shifts left, new column enters on the right
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = above2;
        win[1][2] = above;
        win[2][2] = int'(pix);

        gx = win[0][2] + 2 * win[1][2] + win[2][2] - win[0][0] - 2 * win[1][0] - win[2][0];
        gy = win[2][0] + 2 * win[2][1] + win[2][2] - win[0][0] - 2 * win[0][1] - win[0][2];
        has_word       = (row_pos >= 2) && (col_pos >= 2);
        word.gx_abs    = clip_mag(gx);
        word.gy_abs    = clip_mag(gy);
        word.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);

        // end of row and end of frame, on reaching or passing the limit
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    // random pixel, with the two extremes favoured
    function automatic logic [7:0] rand_pixel();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // let every word due come out and the pipeline empty
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (grads_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_FRAME_WIDTH)
            width_reg = val[FW_W-1:0];
        else
            height_reg = val[FH_W-1:0];
    endtask

    // width write with random bits above the register
    task automatic write_width(input int w);
        write_reg(CFG_IDX_FRAME_WIDTH, {5'($urandom_range(0, 31)), 11'(w)});
    endtask

    // offer one pixel word, wait for it to be taken, queue its result
    task automatic send_pixel(input logic [7:0] pix, input bit use_typed, input bit typed_has,
                              input grad_word_t typed_word);
        int         gap;
        bit         has_word;
        grad_word_t word;
        gap = ((sent_count % 128) < 32) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        sent_count++;
        predict_gradient(pix, has_word, word);
        if (use_typed) begin
            has_word = typed_has;
            word     = typed_word;
        end
        if (has_word)
            grads_due.push_back(word);
    endtask

    task automatic send_random();
        send_pixel(rand_pixel(), 1'b0, 1'b0, NO_WORD);
        small_items++;
    endtask

    // random pixels until the mirror is back at the top left corner
    task automatic run_to_frame_end();
        do
            send_random();
        while (col_pos != 0 || row_pos != 0);
    endtask

    // stimulus
    initial begin
        int big_w;
        int cut_rows;
        int cut_cols;
        int pick;

        width_reg  = FW_W'(WIDTH_AT_RESET);
        height_reg = FH_W'(HEIGHT_AT_RST);
        col_pos    = 0;
        row_pos    = 0;
        for (int i = 0; i < MAX_W; i++) begin
            line_one_up[i] = 0;
            line_two_up[i] = 0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: both registers below their floor, so 3 x 3 frames
        write_reg(CFG_IDX_FRAME_WIDTH, 16'd2);
        write_reg(CFG_IDX_FRAME_HEIGHT, 16'd0);
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].has_word,
                       dir_rows[i].want);

        // one dense frame, long enough for the receiver hold-offs to land in it
        write_width(10);
        write_reg(CFG_IDX_FRAME_HEIGHT, 16'd24);
        run_to_frame_end();

        // random phases of small frames
        small_items = 0;
        while (small_items < SMALL_ITEMS) begin
            pick = $urandom_range(0, 4);
            if (pick == 0) begin
                // tall frame cut short: width and height shrink mid-frame
                big_w    = $urandom_range(6, 12);
                write_width(big_w);
                write_reg(CFG_IDX_FRAME_HEIGHT, 16'hFFFF);
                cut_rows = $urandom_range(3, 5);
                cut_cols = $urandom_range(1, big_w - 1);
                repeat (cut_rows * big_w + cut_cols) send_random();
                write_width($urandom_range(3, big_w - 1));
                write_reg(CFG_IDX_FRAME_HEIGHT, 16'($urandom_range(0, 3)));
                run_to_frame_end();
            end else begin
                // whole frames, width and height mostly small
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    write_width($urandom_range(0, 2));
                else if (pick == 1)
                    write_width(3);
                else
                    write_width($urandom_range(4, 12));
                if ($urandom_range(0, 9) == 0)
                    write_reg(CFG_IDX_FRAME_HEIGHT, 16'($urandom_range(0, 2)));
                else
                    write_reg(CFG_IDX_FRAME_HEIGHT, 16'($urandom_range(3, 6)));
                repeat ($urandom_range(1, 2)) run_to_frame_end();
            end
        end

        // full line length, register at or above the maximum, cut short in
        // the second row and finished at a small width
        write_width($urandom_range(MAX_W, 2047));
        write_reg(CFG_IDX_FRAME_HEIGHT, 16'hFFFF);
        repeat (MAX_W + $urandom_range(1, 24)) send_random();
        write_width($urandom_range(3, 12));
        write_reg(CFG_IDX_FRAME_HEIGHT, 16'd3);
        run_to_frame_end();

        settle_idle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("sobel_abs_gradient_stream_core verification clean");
        else
            $display("sobel_abs_gradient_stream_core verification failed");
        $finish;
    end

    // result side: random stalls, two long hold-offs, field checks
    initial begin
        int         stall;
        grad_word_t seen;
        grad_word_t due;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            stall = ((taken_count % 96) < 24) ? 0 : $urandom_range(0, 4);
            if (taken_count == 100 || taken_count == 160)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1)
                @(posedge aclk);
            seen = '{m_tdata[7:0], m_tdata[15:8], m_tlast};
            taken_count++;
            if (grads_due.size() == 0) begin
                $error("result word with none due: gx %0d gy %0d last %0b",
                       seen.gx_abs, seen.gy_abs, seen.frame_end);
                mismatch_count++;
            end else begin
                due = grads_due.pop_front();
                if (seen.gx_abs !== due.gx_abs) begin
                    $error("grad_x_abs: expected %0d, actual %0d", due.gx_abs, seen.gx_abs);
                    mismatch_count++;
                end
                if (seen.gy_abs !== due.gy_abs) begin
                    $error("grad_y_abs: expected %0d, actual %0d", due.gy_abs, seen.gy_abs);
                    mismatch_count++;
                end
                if (seen.frame_end !== due.frame_end) begin
                    $error("frame_last: expected %0b, actual %0b", due.frame_end,
                           seen.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moved on any channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("sobel_abs_gradient_stream_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sag_pkg.sv
hw/rtl/sag_line_store.sv
hw/rtl/sag_window.sv
hw/rtl/sag_out_fifo.sv
hw/rtl/sobel_abs_gradient_stream_core.sv
hw/rtl/sobel_abs_gradient_stream_core_checker.sv
verif/sobel_abs_gradient_stream_core_tb.sv
